[hdl/art_pkg.sv]
// Address region table: shared types, codes and sizes.
// Used by art_cell, art_ctrl and address_region_table_top.
package art_pkg;

	localparam int ADDR_W       = 48;
	localparam int OFF_W        = 48;
	localparam int ACC_W        = 8;
	localparam int FLG_W        = 16;
	localparam int HND_W        = 11;
	localparam int MAX_REGIONS  = 64;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;
	localparam logic [1:0] OP_GAP    = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_OVERLAP = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_NONE    = 3'd4;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] rstart;
		logic [ADDR_W-1:0] rend;
		logic [ACC_W-1:0]  acc;
		logic [FLG_W-1:0]  flg;
		logic [HND_W-1:0]  hnd;
		logic [OFF_W-1:0]  off;
	} entry_t;

endpackage

[hdl/art_cell.sv]
// One table slot of the region ring; shifts toward its neighbor when enabled.
// Depends on art_pkg.
module art_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  art_pkg::entry_t din,
	output art_pkg::entry_t dout
);
	logic            valid_q;
	art_pkg::entry_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= din;
		end
	end

	always_comb begin
		dout       = data_q;
		dout.valid = valid_q;
	end
endmodule

[hdl/art_ctrl.sv]
// Sequencer at the head of the region ring: runs one pass per table sweep.
// Depends on art_pkg.
module art_ctrl #(
	parameter int MAX_REGIONS = art_pkg::MAX_REGIONS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [art_pkg::ADDR_W-1:0]  range_start,
	input  logic [art_pkg::ADDR_W-1:0]  range_end,
	input  logic [art_pkg::ACC_W-1:0]   access_bits,
	input  logic [art_pkg::FLG_W-1:0]   region_flags,
	input  logic [art_pkg::HND_W-1:0]   file_handle,
	input  logic [art_pkg::OFF_W-1:0]   file_offset,
	input  logic [art_pkg::ADDR_W-1:0]  gap_length,
	input  art_pkg::entry_t             head,
	output art_pkg::entry_t             wb,
	output logic                        shift,
	output logic                        done,
	output logic [2:0]                  status,
	output logic [art_pkg::ADDR_W-1:0]  found_start,
	output logic [art_pkg::ADDR_W-1:0]  found_end,
	output logic [art_pkg::ACC_W-1:0]   found_access,
	output logic [art_pkg::FLG_W-1:0]   found_flags,
	output logic [art_pkg::HND_W-1:0]   found_handle,
	output logic [art_pkg::OFF_W-1:0]   found_offset
);
	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int SW = $clog2(MAX_REGIONS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MOD  = 3'd2;
	localparam logic [2:0] S_INS  = 3'd3;
	localparam logic [2:0] S_FIND = 3'd4;
	localparam logic [2:0] S_GAP  = 3'd5;
	localparam logic [2:0] S_GEND = 3'd6;

	logic [2:0]                 state_q;
	logic [IW-1:0]              idx_q;
	logic [SW-1:0]              step_q;
	logic [1:0]                 op_q;
	logic [art_pkg::ADDR_W-1:0] s_q, e_q, len_q, cur_q;
	logic [art_pkg::ADDR_W-1:0] best_st_q, best_en_q;
	logic                       best_q, gap_q;
	logic                       any_q, free_q, split_q, hit_q;
	logic [IW-1:0]              free_idx_q;
	art_pkg::entry_t            piece_q;

	logic                       last;
	logic                       ov, left, right, cand, better;
	logic [art_pkg::OFF_W-1:0]  moved_off;
	logic [art_pkg::ADDR_W-1:0] tail_room;
	logic                       tail_ok;

	assign busy  = (state_q != S_IDLE);
	assign shift = (state_q == S_SCAN) || (state_q == S_MOD) || (state_q == S_INS) ||
		(state_q == S_FIND) || (state_q == S_GAP);
	assign last  = (idx_q == IW'(MAX_REGIONS - 1));

	assign ov        = head.valid && (head.rstart < e_q) && (head.rend > s_q);
	assign left      = head.rstart < s_q;
	assign right     = e_q < head.rend;
	assign moved_off = head.off + (e_q - head.rstart);
	assign cand      = head.valid && (head.rend > cur_q);
	assign better    = cand && (!best_q || (head.rstart < best_st_q));
	assign tail_room = e_q - len_q;
	assign tail_ok   = (len_q <= e_q) && (cur_q <= tail_room);

	always_comb begin
		wb = head;
		if (state_q == S_MOD && ov) begin
			if (left) begin
				wb.rend = s_q;
			end else if (right) begin
				wb.rstart = e_q;
				wb.off    = moved_off;
			end else begin
				wb.valid = 1'b0;
			end
		end else if (state_q == S_INS && idx_q == free_idx_q) begin
			wb = piece_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			idx_q   <= '0;
		end else begin
			done <= 1'b0;
			if (shift) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if ((operation == art_pkg::OP_ADD || operation == art_pkg::OP_REMOVE) &&
							range_end <= range_start) begin
							done <= 1'b1;
						end else if (operation == art_pkg::OP_FIND) begin
							state_q <= S_FIND;
						end else if (operation == art_pkg::OP_GAP) begin
							state_q <= S_GAP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (last) begin
						if (op_q == art_pkg::OP_ADD) begin
							if ((any_q || ov) || !(free_q || !head.valid)) begin
								state_q <= S_IDLE;
								done    <= 1'b1;
							end else begin
								state_q <= S_INS;
							end
						end else begin
							if (!(any_q || ov)) begin
								state_q <= S_IDLE;
								done    <= 1'b1;
							end else begin
								state_q <= S_MOD;
							end
						end
					end
				end
				S_MOD: begin
					if (last) begin
						if ((split_q || (ov && left && right)) && free_q) begin
							state_q <= S_INS;
						end else begin
							state_q <= S_IDLE;
							done    <= 1'b1;
						end
					end
				end
				S_INS, S_FIND: begin
					if (last) begin
						state_q <= S_IDLE;
						done    <= 1'b1;
					end
				end
				S_GAP: begin
					if (last) begin
						state_q <= S_GEND;
					end
				end
				S_GEND: begin
					if (best_q && !gap_q && step_q != SW'(MAX_REGIONS)) begin
						state_q <= S_GAP;
					end else begin
						state_q <= S_IDLE;
						done    <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q    <= operation;
				s_q     <= range_start;
				e_q     <= range_end;
				len_q   <= gap_length;
				cur_q   <= range_start;
				step_q  <= '0;
				gap_q   <= 1'b0;
				best_q  <= 1'b0;
				any_q   <= 1'b0;
				free_q  <= 1'b0;
				split_q <= 1'b0;
				hit_q   <= 1'b0;
				piece_q <= {1'b1, range_start, range_end, access_bits, region_flags,
					file_handle, file_offset};
				status       <= art_pkg::ST_EMPTY;
				found_start  <= '0;
				found_end    <= '0;
				found_access <= '0;
				found_flags  <= '0;
				found_handle <= '0;
				found_offset <= '0;
			end
			S_SCAN: begin
				if (ov) begin
					any_q <= 1'b1;
				end
				if (!head.valid && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_q;
				end
				if (last) begin
					if (op_q == art_pkg::OP_ADD) begin
						status <= (any_q || ov) ? art_pkg::ST_OVERLAP :
							(free_q || !head.valid) ? art_pkg::ST_OK : art_pkg::ST_FULL;
					end else begin
						status <= (any_q || ov) ? art_pkg::ST_OK : art_pkg::ST_NONE;
					end
				end
			end
			S_MOD: begin
				if (ov && left && right) begin
					split_q <= 1'b1;
					piece_q <= {1'b1, e_q, head.rend, head.acc, head.flg, head.hnd, moved_off};
				end
				if (last) begin
					status <= ((split_q || (ov && left && right)) && !free_q) ?
						art_pkg::ST_FULL : art_pkg::ST_OK;
				end
			end
			S_FIND: begin
				if (!hit_q && head.valid && s_q >= head.rstart && s_q < head.rend) begin
					hit_q        <= 1'b1;
					status       <= art_pkg::ST_OK;
					found_start  <= head.rstart;
					found_end    <= head.rend;
					found_access <= head.acc;
					found_flags  <= head.flg;
					found_handle <= head.hnd;
					found_offset <= head.off;
				end else if (!hit_q) begin
					status <= art_pkg::ST_NONE;
				end
			end
			S_GAP: begin
				if (better) begin
					best_q    <= 1'b1;
					best_st_q <= head.rstart;
					best_en_q <= head.rend;
				end
			end
			S_GEND: begin
				best_q <= 1'b0;
				if (best_q && !gap_q && step_q != SW'(MAX_REGIONS)) begin
					if (best_st_q > cur_q && (best_st_q - cur_q) >= len_q) begin
						gap_q  <= 1'b1;
						step_q <= step_q + 1'b1;
						if (cur_q != '0) begin
							status      <= art_pkg::ST_OK;
							found_start <= cur_q;
						end else begin
							status      <= tail_ok ? art_pkg::ST_NONE : art_pkg::ST_NONE;
							found_start <= '0;
						end
					end else begin
						cur_q  <= best_en_q;
						step_q <= step_q + 1'b1;
					end
				end else if (!(gap_q && cur_q != '0)) begin
					if (tail_ok && cur_q != '0) begin
						status      <= art_pkg::ST_OK;
						found_start <= cur_q;
					end else begin
						status      <= art_pkg::ST_NONE;
						found_start <= '0;
					end
				end
			end
			default: ;
		endcase
	end
endmodule

[hdl/address_region_table_top.sv]
// Address region table top: ring of art_cell slots driven by art_ctrl.
// Depends on art_pkg, art_cell, art_ctrl.
//
// A command is taken when start is high and busy is low; its single result appears with done
// high for one cycle and must be captured then. Each pass sweeps the MAX_REGIONS-slot ring once,
// one slot per cycle past the sequencer. Find is a single pass. Add is a scan pass and an insert
// pass, or the scan pass alone when rejected. Remove is the scan pass alone when nothing overlaps,
// a scan and a modify pass without a split, and a scan, a modify and an insert pass when it
// splits a region and a slot is free. Find gap runs one pass per region it visits in address
// order plus one more pass. Add or remove of an empty range answers without a pass.
module address_region_table_top #(
	parameter int MAX_REGIONS = art_pkg::MAX_REGIONS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        operation,
	input  logic [art_pkg::ADDR_W-1:0]        range_start,
	input  logic [art_pkg::ADDR_W-1:0]        range_end,
	input  logic [art_pkg::ACC_W-1:0]         access_bits,
	input  logic [art_pkg::FLG_W-1:0]         region_flags,
	input  logic signed [art_pkg::HND_W-1:0]  file_handle,
	input  logic [art_pkg::OFF_W-1:0]         file_offset,
	input  logic [art_pkg::ADDR_W-1:0]        gap_length,
	output logic                              done,
	output logic [2:0]                        status,
	output logic [art_pkg::ADDR_W-1:0]        found_start,
	output logic [art_pkg::ADDR_W-1:0]        found_end,
	output logic [art_pkg::ACC_W-1:0]         found_access,
	output logic [art_pkg::FLG_W-1:0]         found_flags,
	output logic signed [art_pkg::HND_W-1:0]  found_handle,
	output logic [art_pkg::OFF_W-1:0]         found_offset
);
	art_pkg::entry_t            ring [MAX_REGIONS];
	art_pkg::entry_t            wb;
	logic                       shift;
	logic [art_pkg::HND_W-1:0]  hnd_raw;

	genvar g;
	generate
		for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
			if (g == MAX_REGIONS - 1) begin : g_tail
				art_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
					.din(wb), .dout(ring[g]));
			end else begin : g_body
				art_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
					.din(ring[g+1]), .dout(ring[g]));
			end
		end
	endgenerate

	art_ctrl #(.MAX_REGIONS(MAX_REGIONS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .range_start(range_start), .range_end(range_end),
		.access_bits(access_bits), .region_flags(region_flags),
		.file_handle(file_handle), .file_offset(file_offset), .gap_length(gap_length),
		.head(ring[0]), .wb(wb), .shift(shift), .done(done), .status(status),
		.found_start(found_start), .found_end(found_end), .found_access(found_access),
		.found_flags(found_flags), .found_handle(hnd_raw), .found_offset(found_offset)
	);

	assign found_handle = hnd_raw;
endmodule
